// ===== rtl/hrhs_pkg.sv =====
package hrhs_pkg;

    // Status line parse position; literal positions first, then scanf fields
    typedef enum logic [3:0] {
        PS_LIT0     = 4'd0,
        PS_LIT1     = 4'd1,
        PS_LIT2     = 4'd2,
        PS_LIT3     = 4'd3,
        PS_LIT4     = 4'd4,
        PS_LIT5     = 4'd5,
        PS_LIT6     = 4'd6,
        PS_SKIP_WS  = 4'd7,
        PS_SKIP_SGN = 4'd8,
        PS_SKIP_DIG = 4'd9,
        PS_CODE_WS  = 4'd10,
        PS_CODE_SGN = 4'd11,
        PS_CODE_DIG = 4'd12,
        PS_DONE     = 4'd13,
        PS_FAIL     = 4'd15
    } parse_step_t;

    localparam logic [15:0] HDR_LIMIT_RST = 16'd511;
    localparam logic [15:0] STATUS_LO     = 16'd200;
    localparam logic [15:0] STATUS_HI     = 16'd300;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd4;
    localparam logic [23:0] TAIL_CRLFCR   = 24'h0D0A0D;
    localparam logic [7:0]  CH_LF         = 8'h0A;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_TAB        = 8'h09;
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_PLUS       = 8'h2B;
    localparam logic [7:0]  CH_MINUS      = 8'h2D;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_NINE       = 8'h39;

    // Expected character of "HTTP/1." at a literal position
    function automatic logic [7:0] lit_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h54; // T
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h2F; // /
            3'd5:    ch = 8'h31; // 1
            3'd6:    ch = 8'h2E; // .
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/http_response_header_splitter_unit.sv =====
// HTTP response header splitter.
//
// Input stream (s_): one response byte per transfer. s_tdata holds the byte,
// s_tlast marks the final byte of a delivered segment, s_tuser = 1 is a start
// command that clears all parse state (its result is all zeros).
// Output stream (m_): exactly one result transfer per input transfer, in order.
// Header bytes are counted and scanned for CR LF CR LF while the status line
// is parsed; the status is committed at the terminator. Once the header limit
// (cfg_wr_en / cfg_wr_data, reset 511) is reached, body mode is forced and
// that byte is dropped. Body bytes pass through with m_tuser = 1.
// Throughput: one transfer per cycle while the receiver takes results, bounded
// by the combinational state update (multiply-by-ten accumulate and window
// compare). Each input transfer passes the input register, then the result register.
// Reset (aresetn low, synchronous) empties both registers and clears the
// parse state; the header limit returns to 511.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until the result is taken.
module http_response_header_splitter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_in_chunk
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] body_byte, [8] headers_done,
                                   // [9] header_end_now, [25:10] status_code,
                                   // [26] status_error, [27] chunk_had_body
    output logic        m_tuser,   // body_valid
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import hrhs_pkg::*;

    // input register
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg,  out_data_next;
    logic        out_body_reg,  out_body_next;

    // config
    logic [15:0] hdr_limit_reg;

    // parse state
    logic        body_phase_reg,   body_phase_next;
    logic [15:0] hdr_count_reg,    hdr_count_next;
    logic [23:0] tail_reg,         tail_next;
    parse_step_t step_reg,         step_next;
    logic [15:0] accum_reg,        accum_next;
    logic        neg_reg,          neg_next;
    logic [15:0] status_reg,       status_next;
    logic        chunk_act_reg,    chunk_act_next;

    logic        advance;
    logic        s_xfer;

    // byte classes
    logic        c_ws, c_dig, c_sgn;
    logic [15:0] accum_x10;
    logic        hdr_byte;   // byte goes through header handling
    logic        term_hit;
    logic        end_now;
    logic        had_body;
    logic        status_err;

    // stage 1 moves into the result register when that is empty or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign c_ws  = (in_byte_reg == CH_SPACE) ||
                   ((in_byte_reg >= CH_TAB) && (in_byte_reg <= CH_CR));
    assign c_dig = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign c_sgn = (in_byte_reg == CH_PLUS) || (in_byte_reg == CH_MINUS);

    // acc*10 + digit, modulo 2^16
    assign accum_x10 = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0}
                     + {12'd0, in_byte_reg[3:0]};

    assign hdr_byte = !body_phase_reg && (hdr_count_reg < hdr_limit_reg);

    // status line parser next state
    always_comb begin
        step_next  = step_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        case (step_reg)
            PS_LIT0, PS_LIT1, PS_LIT2, PS_LIT3, PS_LIT4, PS_LIT5, PS_LIT6: begin
                if (in_byte_reg == lit_char(step_reg[2:0])) begin
                    step_next = parse_step_t'(step_reg + 4'd1);
                end else begin
                    step_next = PS_FAIL;
                end
            end
            PS_SKIP_WS: begin
                if (c_ws) begin
                    step_next = PS_SKIP_WS;
                end else if (c_sgn) begin
                    step_next = PS_SKIP_SGN;
                end else if (c_dig) begin
                    step_next = PS_SKIP_DIG;
                end else begin
                    step_next = PS_FAIL;
                end
            end
            PS_SKIP_SGN: begin
                step_next = c_dig ? PS_SKIP_DIG : PS_FAIL;
            end
            PS_SKIP_DIG, PS_CODE_WS: begin
                if (c_dig) begin
                    if (step_reg == PS_CODE_WS) begin
                        accum_next = {12'd0, in_byte_reg[3:0]};
                        step_next  = PS_CODE_DIG;
                    end
                end else if (c_ws) begin
                    step_next = PS_CODE_WS;
                end else if (c_sgn) begin
                    neg_next  = (in_byte_reg == CH_MINUS);
                    step_next = PS_CODE_SGN;
                end else begin
                    step_next = PS_FAIL;
                end
            end
            PS_CODE_SGN: begin
                if (c_dig) begin
                    accum_next = {12'd0, in_byte_reg[3:0]};
                    step_next  = PS_CODE_DIG;
                end else begin
                    step_next = PS_FAIL;
                end
            end
            PS_CODE_DIG: begin
                if (c_dig) begin
                    accum_next = accum_x10;
                end else begin
                    step_next = PS_DONE;
                end
            end
            default: begin
                step_next = step_reg;
            end
        endcase
    end

    // header/body tracking
    assign hdr_count_next = hdr_count_reg + 16'd1;
    assign tail_next      = {tail_reg[15:0], in_byte_reg};
    assign term_hit       = (hdr_count_next >= MIN_HDR_BYTES) &&
                            (tail_reg == TAIL_CRLFCR) && (in_byte_reg == CH_LF);

    always_comb begin
        body_phase_next = body_phase_reg;
        status_next     = status_reg;
        end_now         = 1'b0;
        if (!body_phase_reg) begin
            if (hdr_byte) begin
                if (term_hit) begin
                    if ((step_next == PS_CODE_DIG) || (step_next == PS_DONE)) begin
                        status_next = neg_next ? (~accum_next + 16'd1) : accum_next;
                    end
                    body_phase_next = 1'b1;
                    end_now         = 1'b1;
                end
            end else begin
                // limit reached: force body mode, drop this byte
                body_phase_next = 1'b1;
                end_now         = 1'b1;
            end
        end
    end

    assign had_body       = in_last_reg && (chunk_act_reg || body_phase_reg);
    assign chunk_act_next = in_last_reg ? 1'b0 : (chunk_act_reg || body_phase_reg);
    assign status_err     = (status_next != 16'd0) &&
                            ((status_next < STATUS_LO) || (status_next >= STATUS_HI));

    // result fields
    always_comb begin
        out_body_next = 1'b0;
        out_data_next = 32'd0;
        if (!in_func_reg) begin
            out_body_next        = body_phase_reg;
            out_data_next[7:0]   = body_phase_reg ? in_byte_reg : 8'd0;
            out_data_next[8]     = body_phase_next;
            out_data_next[9]     = end_now;
            out_data_next[25:10] = status_next;
            out_data_next[26]    = status_err;
            out_data_next[27]    = had_body;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_limit_reg <= HDR_LIMIT_RST;
        end else if (cfg_wr_en) begin
            hdr_limit_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_body_reg <= out_body_next;
        end
    end

    // parse state, updated as each item enters the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_phase_reg <= 1'b0;
            hdr_count_reg  <= 16'd0;
            tail_reg       <= 24'd0;
            step_reg       <= PS_LIT0;
            accum_reg      <= 16'd0;
            neg_reg        <= 1'b0;
            status_reg     <= 16'd0;
            chunk_act_reg  <= 1'b0;
        end else if (advance) begin
            if (in_func_reg) begin
                body_phase_reg <= 1'b0;
                hdr_count_reg  <= 16'd0;
                tail_reg       <= 24'd0;
                step_reg       <= PS_LIT0;
                accum_reg      <= 16'd0;
                neg_reg        <= 1'b0;
                status_reg     <= 16'd0;
                chunk_act_reg  <= 1'b0;
            end else begin
                body_phase_reg <= body_phase_next;
                status_reg     <= status_next;
                chunk_act_reg  <= chunk_act_next;
                if (hdr_byte) begin
                    hdr_count_reg <= hdr_count_next;
                    tail_reg      <= tail_next;
                    step_reg      <= step_next;
                    accum_reg     <= accum_next;
                    neg_reg       <= neg_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_body_reg;

    // body bytes only after the header phase has ended
    a_body_after_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[8])
        else $error("body byte before header end");

    // end-of-header strobe implies body phase entered
    a_end_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("header end without headers_done");

    // error flag only for a nonzero status
    a_err_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26] |-> (m_tdata[25:10] != 16'd0))
        else $error("status_error with zero status");

    // body phase leaves only through a start command
    a_body_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(body_phase_reg) |-> $past(advance && in_func_reg))
        else $error("body phase dropped without start");

    // a held input item stays put until it moves on
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input item lost");

endmodule

// ===== tb/tb_http_response_header_splitter_unit.sv =====
module tb_http_response_header_splitter_unit;
    import hrhs_pkg::*;

    // Status line prefix; character at position p sits at [8*(6-p) +: 8]
    localparam logic [55:0] STATUS_PREFIX = "HTTP/1.";
    localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transfer
    localparam int unsigned LONG_HOLD     = 150;   // receiver back-pressure burst
    localparam int unsigned HOLD_SPACING  = 700;   // results between bursts
    localparam int unsigned SUBRUN_BYTES  = 125;

    // One response byte as offered on the s_ side
    typedef struct packed {
        logic       func;   // start command
        logic [7:0] data;
        logic       last;   // end of delivered segment
    } rx_item_t;

    // Everything the block reports for one byte
    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        headers_done;
        logic        end_now;
        logic [15:0] status;
        logic        status_err;
        logic        chunk_had;
    } byte_outcome_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;   // last_in_chunk
    logic        s_tuser = 1'b0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [7:0] body_byte, [8] headers_done, [9] header_end_now,
                                   // [25:10] status_code, [26] status_error,
                                   // [27] chunk_had_body
    logic        m_tuser;          // body_valid
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    http_response_header_splitter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the splitter state, advanced once per accepted transfer
    // ------------------------------------------------------------------
    logic [15:0] hdr_limit   = HDR_LIMIT_RST;
    logic        in_body     = 1'b0;
    logic [15:0] hdr_count   = '0;
    logic [23:0] tail3       = '0;   // previous three header bytes
    parse_step_t pstep       = PS_LIT0;
    logic [15:0] code_acc    = '0;
    logic        code_neg    = 1'b0;
    logic [15:0] held_status = '0;
    logic        chunk_act   = 1'b0;

    rx_item_t      byte_q[$];        // bytes waiting to be offered
    byte_outcome_t outcome_q[$];     // predicted results, oldest first
    logic [7:0]    line_buf[$];      // text line under construction

    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    // scanf-style walk over "HTTP/1.%*d %hu", one character at a time
    function automatic void scan_status_char(logic [7:0] c);
        logic       ws;
        logic       dg;
        logic       sg;
        logic [7:0] lit;
        ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        dg = (c >= CH_ZERO) && (c <= CH_NINE);
        sg = (c == CH_PLUS) || (c == CH_MINUS);
        if (pstep < PS_SKIP_WS) begin
            lit   = STATUS_PREFIX[8*(6 - int'(pstep)) +: 8];
            pstep = (c == lit) ? parse_step_t'(pstep + 4'd1) : PS_FAIL;
        end else begin
            case (pstep)
                PS_SKIP_WS: begin
                    if (!ws)
                        pstep = sg ? PS_SKIP_SGN : (dg ? PS_SKIP_DIG : PS_FAIL);
                end
                PS_SKIP_SGN: pstep = dg ? PS_SKIP_DIG : PS_FAIL;
                PS_SKIP_DIG, PS_CODE_WS: begin
                    if (dg) begin
                        // digits after the skipped field only count once ws split them
                        if (pstep == PS_CODE_WS) begin
                            code_acc = {8'd0, c - CH_ZERO};
                            pstep    = PS_CODE_DIG;
                        end
                    end else if (ws) begin
                        pstep = PS_CODE_WS;
                    end else if (sg) begin
                        code_neg = (c == CH_MINUS);
                        pstep    = PS_CODE_SGN;
                    end else begin
                        pstep = PS_FAIL;
                    end
                end
                PS_CODE_SGN: begin
                    if (dg) begin
                        code_acc = {8'd0, c - CH_ZERO};
                        pstep    = PS_CODE_DIG;
                    end else begin
                        pstep = PS_FAIL;
                    end
                end
                PS_CODE_DIG: begin
                    if (dg)
                        code_acc = code_acc * 16'd10 + {8'd0, c - CH_ZERO};
                    else
                        pstep = PS_DONE;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic byte_outcome_t next_outcome(rx_item_t it);
        byte_outcome_t o;
        logic [31:0]   win;
        o = '0;
        if (it.func) begin
            // start command: wipe everything except the limit, all-zero result
            in_body     = 1'b0;
            hdr_count   = '0;
            tail3       = '0;
            pstep       = PS_LIT0;
            code_acc    = '0;
            code_neg    = 1'b0;
            held_status = '0;
            chunk_act   = 1'b0;
            return o;
        end
        if (in_body) begin
            o.body_valid = 1'b1;
            o.body_byte  = it.data;
            chunk_act    = 1'b1;
        end else if (hdr_count < hdr_limit) begin
            win       = {tail3, it.data};
            hdr_count = hdr_count + 16'd1;
            tail3     = win[23:0];
            scan_status_char(it.data);
            if (hdr_count >= MIN_HDR_BYTES && win == {TAIL_CRLFCR, CH_LF}) begin
                // status only sticks if the code field got at least one digit
                if (pstep == PS_CODE_DIG || pstep == PS_DONE)
                    held_status = code_neg ? 16'd0 - code_acc : code_acc;
                in_body   = 1'b1;
                o.end_now = 1'b1;
            end
        end else begin
            // limit hit: this byte is dropped and body mode forced
            in_body   = 1'b1;
            o.end_now = 1'b1;
        end
        if (it.last) begin
            o.chunk_had = chunk_act;
            chunk_act   = 1'b0;
        end
        o.headers_done = in_body;
        o.status       = held_status;
        o.status_err   = (held_status != 16'd0) &&
                         (held_status < STATUS_LO || held_status >= STATUS_HI);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, predicts each one as it is accepted
    // ------------------------------------------------------------------
    rx_item_t cur_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(next_outcome(cur_item));
                bytes_accepted++;
            end
            // valid never drops while a transfer is pending
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.data;
                    s_tlast  <= cur_item.last;
                    s_tuser  <= cur_item.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result transfer, owns m_tready
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 200;

    always @(posedge aclk) begin : monitor
        byte_outcome_t got;
        byte_outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.body_valid   = m_tuser;
                got.body_byte    = m_tdata[7:0];
                got.headers_done = m_tdata[8];
                got.end_now      = m_tdata[9];
                got.status       = m_tdata[25:10];
                got.status_err   = m_tdata[26];
                got.chunk_had    = m_tdata[27];
                if (outcome_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("body_valid", want.body_valid, got.body_valid);
                    check_field("body_byte", want.body_byte, got.body_byte);
                    check_field("headers_done", want.headers_done, got.headers_done);
                    check_field("header_end_now", want.end_now, got.end_now);
                    check_field("status_code", want.status, got.status);
                    check_field("status_error", want.status_err, got.status_err);
                    check_field("chunk_had_body", want.chunk_had, got.chunk_had);
                end
            end
            // long back-pressure bursts so the input side fills and stalls
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (results_seen >= next_hold_at) begin
                hold_left    <= LONG_HOLD;
                next_hold_at <= next_hold_at + HOLD_SPACING;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(logic func, logic [7:0] data, logic last);
        rx_item_t it;
        it.func = func;
        it.data = data;
        it.last = last;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    function automatic logic rand_last();
        return ($urandom_range(7) == 0);
    endfunction

    function automatic logic [7:0] rand_ws();
        if ($urandom_range(2) != 0)
            return CH_SPACE;
        return CH_TAB + 8'($urandom_range(4));   // TAB, LF, VT, FF, CR
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_digits(int unsigned n);
        repeat (n)
            line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic add_word();
        repeat ($urandom_range(2, 8))
            line_buf.push_back(8'h61 + 8'($urandom_range(25)));   // a..z
    endtask

    task automatic add_crlf();
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
    endtask

    // push the line out, now and then with one byte smashed
    task automatic flush_line(logic may_corrupt);
        if (may_corrupt && line_buf.size() != 0 && $urandom_range(9) == 0)
            line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom);
        foreach (line_buf[i])
            queue_item(1'b0, line_buf[i], rand_last());
        line_buf.delete();
    endtask

    // one response: usually a start, status line, up to three header lines, blank line, body
    task automatic queue_response();
        int unsigned kind;
        if ($urandom_range(11) == 0)
            repeat ($urandom_range(1, 10)) queue_item(1'b0, 8'($urandom), rand_last());
        if ($urandom_range(9) != 0)
            queue_item(1'b1, 8'($urandom), 1'($urandom_range(1)));
        kind = $urandom_range(11);
        if (kind == 0) begin
            repeat ($urandom_range(3, 20)) line_buf.push_back(8'($urandom));
            add_crlf();
            flush_line(1'b0);
        end else if (kind != 1) begin
            // kind 1 leaves just the blank line: smallest possible header
            add_text("HTTP/1.");
            if ($urandom_range(7) == 0)
                line_buf.push_back(rand_ws());
            if ($urandom_range(7) == 0)
                line_buf.push_back(rand_sign());
            add_digits($urandom_range(1, 2));
            repeat ($urandom_range(2)) line_buf.push_back(rand_ws());
            if ($urandom_range(4) == 0)
                line_buf.push_back(rand_sign());
            case ($urandom_range(4))
                0:       add_text($sformatf("%0d", $urandom_range(65535)));
                1:       add_digits($urandom_range(6, 9));   // wraps mod 65536
                default: add_text($sformatf("%0d", $urandom_range(100, 599)));
            endcase
            line_buf.push_back(CH_SPACE);
            add_word();
            add_crlf();
            flush_line(1'b1);
            repeat ($urandom_range(3)) begin
                add_word();
                add_text(": ");
                add_word();
                add_crlf();
                flush_line(1'b1);
            end
        end
        add_crlf();
        flush_line(1'b0);
        repeat ($urandom_range(24)) queue_item(1'b0, 8'($urandom), rand_last());
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || results_seen != bytes_accepted)
            @(posedge aclk);
        repeat (4) @(posedge aclk);   // covers the two-stage pipe
    endtask

    task automatic write_header_limit(logic [15:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hdr_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        string       short_resp;
        logic [15:0] limits [9];
        int unsigned mark;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: clean 404 at reset limit, NUL and 0xFF body bytes
        short_resp = "HTTP/1.1 404";
        queue_item(1'b1, 8'h00, 1'b0);
        for (int i = 0; i < short_resp.len(); i++)
            queue_item(1'b0, short_resp[i], 1'b0);
        queue_item(1'b0, CH_CR, 1'b0);
        queue_item(1'b0, CH_LF, 1'b0);
        queue_item(1'b0, CH_CR, 1'b0);
        queue_item(1'b0, CH_LF, 1'b1);   // segment end with no body yet
        queue_item(1'b0, 8'hFF, 1'b0);
        queue_item(1'b0, 8'h00, 1'b1);
        queue_item(1'b1, 8'hFF, 1'b1);
        // zero limit: first byte forces body mode and is dropped
        write_header_limit(16'd0);
        queue_item(1'b0, CH_CR, 1'b0);
        queue_item(1'b0, 8'h41, 1'b1);

        limits = '{16'hFFFF, 16'd4, 16'($urandom_range(20, 80)),
                   16'd0, HDR_LIMIT_RST, 16'd3,
                   16'($urandom_range(5, 60)), 16'hFFFF, 16'($urandom_range(100, 400))};

        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       begin send_idle_pct = 14; recv_idle_pct = 67; end
                1:       begin send_idle_pct = 67; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int s = 0; s < 3; s++) begin
                write_header_limit(limits[p*3 + s]);
                mark = bytes_queued;
                while (bytes_queued - mark < SUBRUN_BYTES)
                    queue_response();
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
